### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/scba_pkg.sv
// ---------------------------------------------------------------------------
// scba_pkg
// Types and fixed constants of the size class bitmap allocator.
// ---------------------------------------------------------------------------
package scba_pkg;

	localparam int ADDR_W    = 18;
	localparam int SIZE_W    = 12;
	localparam int CLS_W     = 4;
	localparam int BYTES_W   = 12;
	localparam int CNT_W     = 7;
	localparam int MIN_SHIFT = 3;   // smallest block is 8 bytes

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOMEM   = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_status;
		logic [ADDR_W-1:0]  granted_addr;
		logic [CLS_W-1:0]   class_index;
		logic [BYTES_W-1:0] block_bytes;
		logic [CNT_W-1:0]   used_count;
	} rsp_t;

	// Request decode: early failure and starting class
	typedef struct packed {
		logic             fail;
		logic [1:0]       status;
		logic [CLS_W-1:0] cls;
	} dec_t;

endpackage

### src/scba_ram.sv
// ---------------------------------------------------------------------------
// scba_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module scba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/scba_decode.sv
// ---------------------------------------------------------------------------
// scba_decode
// Request decode: fitting class for an allocate, holding region for a free
// or query, and the failures known before any bitmap is read.
// ---------------------------------------------------------------------------
module scba_decode #(
	parameter int BLOCKS_PER_CLASS = 64,
	parameter int NUM_CLASSES      = 9
) (
	input  scba_pkg::req_t req,
	output scba_pkg::dec_t dec
);
	import scba_pkg::*;

	always_comb begin
		logic found;
		found      = 1'b0;
		dec.fail   = 1'b0;
		dec.status = ST_OK;
		dec.cls    = '0;
		case (req.op)
			OP_ALLOC: begin
				if (req.req_size == '0) begin
					dec.fail   = 1'b1;
					dec.status = ST_INVALID;
				end else begin
					// smallest class whose block size covers the request
					for (int c = 0; c < NUM_CLASSES; c++) begin
						if (!found && ({1'b0, req.req_size} <=
							(SIZE_W+1)'(1 << (MIN_SHIFT + c)))) begin
							found   = 1'b1;
							dec.cls = CLS_W'(c);
						end
					end
					if (!found) begin
						dec.fail   = 1'b1;
						dec.status = ST_NOMEM;
					end
				end
			end
			OP_FREE, OP_QUERY: begin
				// first region whose upper end lies above the address
				for (int c = 0; c < NUM_CLASSES; c++) begin
					if (!found && ({1'b0, req.block_addr} < (ADDR_W+1)'(
						(BLOCKS_PER_CLASS * ((2 << c) - 1)) << MIN_SHIFT))) begin
						found   = 1'b1;
						dec.cls = CLS_W'(c);
					end
				end
				if (!found) begin
					dec.fail   = 1'b1;
					dec.status = ST_OUTSIDE;
				end
			end
			default: begin
				dec.fail   = 1'b1;
				dec.status = ST_INVALID;
			end
		endcase
	end

endmodule

### src/size_class_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// size_class_bitmap_allocator
// Power-of-two size class pool allocator with one bitmap per class.
// ---------------------------------------------------------------------------
// One request word at a time: req_stall is high outside S_IDLE. A free
// or query reads its class entry on accept, forms its result word in
// S_EVAL, and S_RESP moves that word onto rsp as the block returns to
// S_IDLE. An allocate stays in S_EVAL for one more class read for every
// full class it steps over. A request that fails in decode (zero size,
// oversize, unused op, address outside the pool) goes from accept
// straight to S_RESP. A result word held by rsp_stall keeps the next
// result in S_RESP, and so stalls the next request, once that result is
// ready behind it. The per-class entry memory ({used count, bitmap}) has
// one read port with a registered read, so the allocate search reads one
// class per cycle. Entries never written read as empty through a valid
// bit per class, so no clearing pass runs after reset. The result register
// lets the next request enter while a result still waits on rsp_stall.
`include "assert_macros.svh"

module size_class_bitmap_allocator #(
	parameter int BLOCKS_PER_CLASS = 64,
	parameter int NUM_CLASSES      = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  scba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output scba_pkg::rsp_t rsp
);
	import scba_pkg::*;

	localparam int RAM_AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int IDX_W  = $clog2(BLOCKS_PER_CLASS);
	localparam int ENT_W  = CNT_W + BLOCKS_PER_CLASS;
	localparam logic [ADDR_W-1:0] REGION0 = ADDR_W'(BLOCKS_PER_CLASS << MIN_SHIFT);

	// byte offset of region c: REGION0 * (2^c - 1)
	function automatic logic [ADDR_W-1:0] base_of(input logic [CLS_W-1:0] c);
		return (REGION0 << c) - REGION0;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_set(
		input logic [BLOCKS_PER_CLASS-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = BLOCKS_PER_CLASS - 1; i >= 0; i--) begin
			if (v[i]) idx = IDX_W'(i);
		end
		return idx;
	endfunction

	state_t                state_q, state_d;
	req_t                  req_q;
	logic [CLS_W-1:0]      cls_q, cls_d;
	logic                  cls_ld;
	rsp_t                  res_q, res_d;
	logic                  res_ld;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  rsp_ld;
	logic [NUM_CLASSES-1:0] vld_q;
	logic                  rdv_q;

	dec_t                  dec;
	logic                  acc;

	logic                  wr_en, rd_en;
	logic [RAM_AW-1:0]     wr_addr, rd_addr;
	logic [ENT_W-1:0]      wr_data, rd_data;

	logic [ENT_W-1:0]            ent;
	logic [BLOCKS_PER_CLASS-1:0] ent_map, free_map;
	logic [CNT_W-1:0]            ent_cnt, cnt_up, cnt_dn;
	logic [CLS_W-1:0]            cls_nx;
	logic [CLS_W:0]              shamt;
	logic [BYTES_W-1:0]          bytes;
	logic [ADDR_W-1:0]           base;
	logic [IDX_W-1:0]            fidx, blk;
	logic                        any_free, blk_set, last_cls, is_alloc, is_free;
	logic                        do_clear;

	scba_decode #(
		.BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
		.NUM_CLASSES      (NUM_CLASSES)
	) u_decode (
		.req (req),
		.dec (dec)
	);

	scba_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_CLASSES)
	) u_ent_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;

	// entry under evaluation; unwritten classes are empty
	assign ent      = rdv_q ? rd_data : '0;
	assign ent_map  = ent[BLOCKS_PER_CLASS-1:0];
	assign ent_cnt  = ent[ENT_W-1 -: CNT_W];
	assign cnt_up   = ent_cnt + CNT_W'(1);
	assign free_map = ~ent_map;
	assign any_free = |free_map;
	assign fidx     = lowest_set(free_map);

	assign cls_nx   = cls_q + CLS_W'(1);
	assign last_cls = (cls_nx == CLS_W'(NUM_CLASSES));
	assign shamt    = {1'b0, cls_q} + (CLS_W+1)'(MIN_SHIFT);
	assign bytes    = BYTES_W'(1 << MIN_SHIFT) << cls_q;
	assign base     = base_of(cls_q);

	// block holding the free/query address
	assign blk      = IDX_W'((req_q.block_addr - base) >> shamt);
	assign blk_set  = ent_map[blk];
	assign is_alloc = (req_q.op == OP_ALLOC);
	assign is_free  = (req_q.op == OP_FREE);
	assign do_clear = is_free && blk_set;
	assign cnt_dn   = (do_clear && ent_cnt != '0) ? ent_cnt - CNT_W'(1) : ent_cnt;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) state_d = dec.fail ? S_RESP : S_EVAL;
			end
			S_EVAL: begin
				if (!is_alloc || any_free || last_cls) state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory access and result formation
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = dec.cls[RAM_AW-1:0];
		wr_en   = 1'b0;
		wr_addr = cls_q[RAM_AW-1:0];
		wr_data = ent;
		res_d   = '0;
		res_ld  = 1'b0;
		cls_ld  = 1'b0;
		cls_d   = dec.cls;
		rsp_ld  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cls_ld = 1'b1;
					if (dec.fail) begin
						res_ld              = 1'b1;
						res_d.result_status = dec.status;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_EVAL: begin
				if (is_alloc) begin
					if (any_free) begin
						// take lowest free block
						wr_en   = 1'b1;
						wr_data = {cnt_up, ent_map | (BLOCKS_PER_CLASS'(1) << fidx)};
						res_ld  = 1'b1;
						res_d.result_status = ST_OK;
						res_d.granted_addr  = base + (ADDR_W'(fidx) << shamt);
						res_d.class_index   = cls_q;
						res_d.block_bytes   = bytes;
						res_d.used_count    = cnt_up;
					end else if (last_cls) begin
						res_ld              = 1'b1;
						res_d.result_status = ST_NOMEM;
					end else begin
						// class full: move up one class
						rd_en   = 1'b1;
						rd_addr = cls_nx[RAM_AW-1:0];
						cls_ld  = 1'b1;
						cls_d   = cls_nx;
					end
				end else begin
					wr_en   = do_clear;
					wr_data = {cnt_dn, ent_map & ~(BLOCKS_PER_CLASS'(1) << blk)};
					res_ld  = 1'b1;
					res_d.result_status = ST_OK;
					res_d.class_index   = cls_q;
					res_d.block_bytes   = bytes;
					res_d.used_count    = cnt_dn;
				end
			end
			S_RESP: begin
				rsp_ld = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				rsp_ld = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) req_q <= req;
		if (cls_ld) cls_q <= cls_d;
		if (res_ld) res_q <= res_d;
		if (rd_en) rdv_q <= vld_q[rd_addr];
		if (rsp_ld) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEXT(a_wr_ends_item, clk, arst_n, wr_en, state_q == S_RESP, "write not followed by response")
	`ASSERT_AT(a_eval_cls_range, clk, arst_n, state_q == S_EVAL |-> cls_q < CLS_W'(NUM_CLASSES), "class out of range in search")
	`ASSERT_AT(a_fail_zero, clk, arst_n, rsp_ld && res_q.result_status != ST_OK |-> res_q.granted_addr == '0 && res_q.class_index == '0 && res_q.used_count == '0, "failure result carries data")
	`ASSERT_AT(a_no_rd_on_wr, clk, arst_n, wr_en |-> !rd_en, "read and write in one cycle")

endmodule

### tb/sv/tb_size_class_bitmap_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_size_class_bitmap_allocator
// Self-checking bench for the size class bitmap allocator. A scoreboard
// keeps its own copy of the class bitmaps and used counters, works out the
// answer to every accepted request word and checks each result word against
// the oldest answer due. Directed corner cases come first, then rounds of
// mixed traffic, pool fills and free sweeps under random idling on both
// sides, one long result hold-off and pauses until the pool goes quiet.
// ---------------------------------------------------------------------------
module tb_size_class_bitmap_allocator;
	import scba_pkg::*;

	localparam int          BLOCKS    = 64;
	localparam int          CLASSES   = 9;
	localparam int          POOL_END  = BLOCKS * 8 * ((1 << CLASSES) - 1);
	localparam int          ITEMS     = 1250;
	localparam int          MAX_IDLE  = 18;
	localparam int          ADDR_TOP  = (1 << ADDR_W) - 1;
	localparam int          SIZE_TOP  = (1 << SIZE_W) - 1;
	localparam int          LATENCY   = CLASSES + 2;
	localparam logic [1:0]  OP_UNUSED = 2'd3;

	class pool_scoreboard;
		logic [BLOCKS-1:0] bitmap [CLASSES];
		logic [CNT_W-1:0]  in_use [CLASSES];
		rsp_t              answers_due [$];
		int                errors;
		int                words_in;
		int                words_out;
		int                op_seen [4];
		int                status_seen [4];

		function new();
			foreach (bitmap[k]) begin
				bitmap[k] = '0;
				in_use[k] = '0;
			end
		endfunction

		function int cls_bytes(int k);
			return 8 << k;
		endfunction

		// regions lie back to back, so base(k + 1) is also the end of region k
		function int cls_base(int k);
			return BLOCKS * 8 * ((1 << k) - 1);
		endfunction

		// Pool's answer to one request; updates bitmaps and counters
		function rsp_t pool_answer(req_t w);
			rsp_t a;
			int   first;
			int   k;
			int   b;
			int   idx;
			int   addr;
			bit   found;
			a = '0;
			addr = int'(w.block_addr);
			found = 1'b0;
			case (w.op)
			OP_ALLOC: begin
				if (w.req_size == 0) begin
					a.result_status = ST_INVALID;
				end else begin
					a.result_status = ST_NOMEM;
					first = CLASSES;
					for (k = CLASSES - 1; k >= 0; k--)
						if (w.req_size <= cls_bytes(k)) first = k;
					// walk up from the fitting class, take the lowest free block
					for (k = first; k < CLASSES && !found; k++) begin
						if (~bitmap[k] != '0) begin
							idx = 0;
							for (b = BLOCKS - 1; b >= 0; b--)
								if (!bitmap[k][b]) idx = b;
							bitmap[k][idx] = 1'b1;
							in_use[k] = in_use[k] + 1'b1;
							a.result_status = ST_OK;
							a.granted_addr = ADDR_W'(cls_base(k) + idx * cls_bytes(k));
							a.class_index = CLS_W'(k);
							a.block_bytes = BYTES_W'(cls_bytes(k));
							a.used_count = in_use[k];
							found = 1'b1;
						end
					end
				end
			end
			OP_FREE, OP_QUERY: begin
				first = CLASSES;
				for (k = 0; k < CLASSES; k++)
					if (addr >= cls_base(k) && addr < cls_base(k + 1)) first = k;
				if (first == CLASSES) begin
					a.result_status = ST_OUTSIDE;
				end else begin
					// unaligned addresses act on the block holding that byte
					if (w.op == OP_FREE) begin
						idx = (addr - cls_base(first)) / cls_bytes(first);
						if (bitmap[first][idx]) begin
							bitmap[first][idx] = 1'b0;
							if (in_use[first] != 0) in_use[first] = in_use[first] - 1'b1;
						end
					end
					a.result_status = ST_OK;
					a.class_index = CLS_W'(first);
					a.block_bytes = BYTES_W'(cls_bytes(first));
					a.used_count = in_use[first];
				end
			end
			default: a.result_status = ST_INVALID;
			endcase
			return a;
		endfunction

		function void note_request(req_t w);
			words_in++;
			op_seen[w.op]++;
			answers_due.push_back(pool_answer(w));
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_answer(rsp_t got);
			rsp_t want;
			words_out++;
			if (!$isunknown(got.result_status)) status_seen[got.result_status]++;
			if (answers_due.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, expected none, actual %h",
					$time, got);
			end else begin
				want = answers_due.pop_front();
				compare_field("result_status", 32'(want.result_status),
					32'(got.result_status));
				compare_field("granted_addr", 32'(want.granted_addr), 32'(got.granted_addr));
				compare_field("class_index", 32'(want.class_index), 32'(got.class_index));
				compare_field("block_bytes", 32'(want.block_bytes), 32'(got.block_bytes));
				compare_field("used_count", 32'(want.used_count), 32'(got.used_count));
			end
		endfunction
	endclass

	typedef enum {ROUND_MIX, ROUND_FILL, ROUND_SWEEP} round_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	pool_scoreboard sb = new();
	bit             quiet = 1'b0;
	int             rx_hold = 0;
	int             words_sent = 0;

	size_class_bitmap_allocator #(
		.BLOCKS_PER_CLASS(BLOCKS),
		.NUM_CLASSES(CLASSES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	function automatic req_t mk(logic [1:0] op, int size, int addr);
		req_t w;
		w.op = op;
		w.req_size = SIZE_W'(size);
		w.block_addr = ADDR_W'(addr);
		return w;
	endfunction

	// allocate sized to land in a class between lo and hi
	function automatic req_t pick_alloc(int lo, int hi);
		int k;
		int size;
		k = $urandom_range(lo, hi);
		size = (k == 0) ? $urandom_range(1, 8) : $urandom_range((4 << k) + 1, 8 << k);
		return mk(OP_ALLOC, size, $urandom_range(0, ADDR_TOP));
	endfunction

	// free or query some byte inside block idx of class k
	function automatic req_t pick_block(logic [1:0] op, int k, int idx);
		int bytes;
		bytes = sb.cls_bytes(k);
		return mk(op, $urandom_range(0, SIZE_TOP),
			sb.cls_base(k) + idx * bytes + $urandom_range(0, bytes - 1));
	endfunction

	// low blocks are the ones allocated, so frees favor them
	function automatic int low_block();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCKS - 1) :
			$urandom_range(0, 15);
	endfunction

	function automatic req_t mixed_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return pick_alloc(0, CLASSES - 1);
		if (r < 78) return pick_block(OP_FREE, $urandom_range(0, CLASSES - 1), low_block());
		if (r < 93) return pick_block(OP_QUERY, $urandom_range(0, CLASSES - 1), low_block());
		// noise: bad ops, bad sizes, addresses past the pool, raw random words
		case ($urandom_range(0, 4))
		0: return mk(OP_UNUSED, $urandom_range(0, SIZE_TOP), $urandom_range(0, ADDR_TOP));
		1: return mk(OP_ALLOC, 0, $urandom_range(0, ADDR_TOP));
		2: return mk(OP_ALLOC, $urandom_range(2049, SIZE_TOP), $urandom_range(0, ADDR_TOP));
		3: return mk($urandom_range(0, 1) ? OP_FREE : OP_QUERY, $urandom_range(0, SIZE_TOP),
			$urandom_range(POOL_END, ADDR_TOP));
		default: return mk(2'($urandom_range(0, 3)), $urandom_range(0, SIZE_TOP),
			$urandom_range(0, ADDR_TOP));
		endcase
	endfunction

	// Offer one request word after a random gap, hold it until taken
	task automatic send_word(input req_t w);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		words_sent++;
	endtask

	// Sender goes quiet until every answer due has come back
	task automatic wait_all_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.answers_due.size() != 0);
	endtask

	// Accepted words on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_request(req);
			if (rsp_valid && !rsp_stall) sb.check_answer(rsp);
		end
	end

	// Result side: random stall before each word, one long hold on request
	initial begin : result_sink
		int n;
		rsp_stall = 1'b0;
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = quiet ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Stimulus
	initial begin : stimulus
		req_t        plan [$];
		round_kind_t kind;
		int          round;
		int          k;
		int          n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases: bad sizes, allocates at or near class edges, odd frees and queries, an unused op
		plan = '{
			mk(OP_ALLOC, 0, 0),
			mk(OP_ALLOC, SIZE_TOP, ADDR_TOP),
			mk(OP_ALLOC, 2049, 0),
			mk(OP_ALLOC, 1, 0),
			mk(OP_ALLOC, 8, 0),
			mk(OP_ALLOC, 9, 0),
			mk(OP_ALLOC, 16, 0),
			mk(OP_ALLOC, 33, 0),
			mk(OP_ALLOC, 64, 0),
			mk(OP_ALLOC, 200, 0),
			mk(OP_ALLOC, 256, 0),
			mk(OP_ALLOC, 700, 0),
			mk(OP_ALLOC, 1024, 0),
			mk(OP_ALLOC, 2048, 0),
			mk(OP_FREE, 0, 4),
			mk(OP_FREE, 0, 4),
			mk(OP_QUERY, 0, POOL_END - 1),
			mk(OP_QUERY, 0, POOL_END),
			mk(OP_FREE, SIZE_TOP, ADDR_TOP),
			mk(OP_FREE, 0, sb.cls_base(CLASSES - 1) + 100),
			mk(OP_QUERY, 0, 0),
			mk(OP_UNUSED, SIZE_TOP, ADDR_TOP),
			mk(OP_ALLOC, 2048, 0),
			mk(OP_FREE, 0, sb.cls_base(1) - 1),
			mk(OP_ALLOC, 5, 0)
		};
		foreach (plan[i]) send_word(plan[i]);
		wait_all_results();

		// first round fills the top class into out of memory, next drains it
		round = 0;
		while (words_sent < plan.size() + ITEMS) begin
			quiet = (round > 1) && ($urandom_range(0, 3) == 0);
			if (round == 3) rx_hold = 400;
			if (round == 6) wait_all_results();
			if (round == 0) kind = ROUND_FILL;
			else if (round == 1) kind = ROUND_SWEEP;
			else kind = round_kind_t'($urandom_range(0, 3) % 3);
			case (kind)
			ROUND_FILL: begin
				k = (round == 0) ? CLASSES - 1 : $urandom_range(0, CLASSES - 1);
				for (n = 0; n < 100; n++)
					send_word(($urandom_range(0, 9) != 0) ? pick_alloc(k, k) : mixed_word());
			end
			ROUND_SWEEP: begin
				k = (round == 1) ? CLASSES - 1 : $urandom_range(0, CLASSES - 1);
				for (n = 0; n < BLOCKS; n++)
					send_word(($urandom_range(0, 6) != 0) ? pick_block(OP_FREE, k, n) :
						pick_block(OP_QUERY, k, $urandom_range(0, BLOCKS - 1)));
			end
			default: begin
				for (n = 0; n < 60; n++) send_word(mixed_word());
			end
			endcase
			round++;
		end

		quiet = 1'b0;
		wait_all_results();
		repeat (2 * LATENCY) @(posedge clk);
		if (sb.answers_due.size() != 0) begin
			sb.errors++;
			$display("%0t: answers never returned, expected 0 pending, actual %0d",
				$time, sb.answers_due.size());
		end
		$display("Sent %0d words in %0d rounds: %0d allocate, %0d free, %0d query, %0d unused op",
			sb.words_in, round, sb.op_seen[OP_ALLOC], sb.op_seen[OP_FREE],
			sb.op_seen[OP_QUERY], sb.op_seen[OP_UNUSED]);
		$display("Checked %0d results: ok %0d, invalid %0d, out of memory %0d, outside %0d",
			sb.words_out, sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
			sb.status_seen[ST_NOMEM], sb.status_seen[ST_OUTSIDE]);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d answers still due", $time, sb.answers_due.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/scba_pkg.sv
src/scba_ram.sv
src/scba_decode.sv
src/size_class_bitmap_allocator.sv
tb/sv/tb_size_class_bitmap_allocator.sv
